// File: hdl/hav_pkg.sv
// Package for the haversine distance pipeline: fixed-point types, CORDIC
// arctangent table, scale constants and the Q30 multiply and clamp helpers.
// No dependencies.
package hav_pkg;

   typedef logic signed [31:0] q30_type;
   typedef logic signed [33:0] cor_type;
   typedef logic signed [32:0] phase_type;

   localparam int CORDIC_ITERS = 30;
   localparam int SQRT_STEPS = 31;
   localparam int LANES = 4;

   localparam logic [6:0] PHASE_DIV = 7'd45;
   localparam cor_type GAIN_INV_Q30 = 34'sd652032874;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [32:0] DIST_SCALE = 33'd5246834913;

   function automatic phase_type atan_phase(input int k);
      phase_type r;
      case (k)
         0: r = 33'sd536870912;
         1: r = 33'sd316933406;
         2: r = 33'sd167458907;
         3: r = 33'sd85004756;
         4: r = 33'sd42667331;
         5: r = 33'sd21354465;
         6: r = 33'sd10679838;
         7: r = 33'sd5340245;
         8: r = 33'sd2670163;
         9: r = 33'sd1335087;
         10: r = 33'sd667544;
         11: r = 33'sd333772;
         12: r = 33'sd166886;
         13: r = 33'sd83443;
         14: r = 33'sd41722;
         15: r = 33'sd20861;
         16: r = 33'sd10430;
         17: r = 33'sd5215;
         18: r = 33'sd2608;
         19: r = 33'sd1304;
         20: r = 33'sd652;
         21: r = 33'sd326;
         22: r = 33'sd163;
         23: r = 33'sd81;
         24: r = 33'sd41;
         25: r = 33'sd20;
         26: r = 33'sd10;
         27: r = 33'sd5;
         28: r = 33'sd3;
         29: r = 33'sd1;
         default: r = 33'sd0;
      endcase
      return r;
   endfunction

   // Q30 product, rounded half up toward positive infinity.
   function automatic q30_type mulq(input q30_type a, input q30_type b);
      logic signed [63:0] p;
      p = a * b;
      p = p + (64'sd1 <<< 29);
      return 32'(p >>> 30);
   endfunction

   function automatic q30_type clamp_q30(input cor_type v);
      q30_type r;
      if (v > 34'sd1073741824) begin
         r = 32'sd1073741824;
      end else if (v < -34'sd1073741824) begin
         r = -32'sd1073741824;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

// File: hdl/haversine_distance.sv
// Haversine great-circle distance pipeline, top level.
// Depends on hav_pkg for types, the arctangent table and scale constants.
//
// Takes one pair of points per cycle while the output is not stalled, and
// returns the distance on a 6371 km sphere in units of 1/1024 km, one
// result per pair, in order. The pipeline consists mostly of the two
// 30-stage CORDIC chains and the 31-stage square root, with one CORDIC
// iteration or one root digit per stage. The whole pipeline holds while
// a finished result is stalled at the output.
module haversine_distance #(
   parameter int ANGLE_FRAC_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [27:0] req_lat_a,
   input  logic signed [28:0] req_lon_a,
   input  logic signed [27:0] req_lat_b,
   input  logic signed [28:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [24:0]        rsp_distance
);
   import hav_pkg::*;

   localparam int DW = 60 - ANGLE_FRAC_BITS;
   localparam int DIV_ST = (DW + 7) / 8;
   localparam int LAT = DIV_ST + 102;

   logic adv;
   logic [LAT-1:0] vld_ff;

   assign adv = ~vld_ff[LAT-1] | ~rsp_stall;
   assign req_stall = ~adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // Lane 0: latitude difference, lane 1: longitude difference (half angles),
   // lanes 2 and 3: the two latitudes.
   logic signed [29:0] ang_ff [0:LANES-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff[0] <= 30'(req_lat_b) - 30'(req_lat_a);
         ang_ff[1] <= 30'(req_lon_b) - 30'(req_lon_a);
         ang_ff[2] <= 30'(req_lat_a);
         ang_ff[3] <= 30'(req_lat_b);
      end
   end

   // Degrees to phase: divide by 720 or 360 as a shift and a long division
   // by 45, eight quotient bits per stage.
   logic [DW-1:0] dnum_ff [0:DIV_ST][0:LANES-1];
   logic [5:0]    drem_ff [0:DIV_ST][0:LANES-1];
   logic [31:0]   dquo_ff [0:DIV_ST][0:LANES-1];
   logic          dneg_ff [0:DIV_ST][0:LANES-1];

   for (genvar l = 0; l < LANES; l++) begin : g_div0
      localparam int SH = (l < 2) ? 28 - ANGLE_FRAC_BITS : 29 - ANGLE_FRAC_BITS;
      logic [29:0] mag;
      always_comb begin
         mag = ang_ff[l][29] ? 30'(-ang_ff[l]) : 30'(ang_ff[l]);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dnum_ff[0][l] <= (DW'(mag) << SH) + DW'(22);
            drem_ff[0][l] <= '0;
            dquo_ff[0][l] <= '0;
            dneg_ff[0][l] <= ang_ff[l][29];
         end
      end
   end

   for (genvar s = 1; s <= DIV_ST; s++) begin : g_div
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DW-1:0] num_in;
         logic [5:0]    rem_in;
         logic [31:0]   quo_in;
         logic [6:0]    t;
         always_comb begin
            num_in = dnum_ff[s-1][l];
            rem_in = drem_ff[s-1][l];
            quo_in = dquo_ff[s-1][l];
            t = '0;
            for (int j = 0; j < 8; j++) begin
               if ((s - 1) * 8 + j < DW) begin
                  t = {rem_in, num_in[DW-1]};
                  num_in = num_in << 1;
                  if (t >= PHASE_DIV) begin
                     rem_in = 6'(t - PHASE_DIV);
                     quo_in = {quo_in[30:0], 1'b1};
                  end else begin
                     rem_in = t[5:0];
                     quo_in = {quo_in[30:0], 1'b0};
                  end
               end
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dnum_ff[s][l] <= num_in;
               drem_ff[s][l] <= rem_in;
               dquo_ff[s][l] <= quo_in;
               dneg_ff[s][l] <= dneg_ff[s-1][l];
            end
         end
      end
   end

   // Rotation CORDIC for sine and cosine, one iteration per stage.
   cor_type   rx_ff [0:CORDIC_ITERS][0:LANES-1];
   cor_type   ry_ff [0:CORDIC_ITERS][0:LANES-1];
   phase_type rz_ff [0:CORDIC_ITERS][0:LANES-1];
   logic      rflip_ff [0:CORDIC_ITERS][0:LANES-1];

   for (genvar l = 0; l < LANES; l++) begin : g_fold
      logic [31:0] ph;
      logic        flip;
      always_comb begin
         ph = dneg_ff[DIV_ST][l] ? 32'(-dquo_ff[DIV_ST][l]) : dquo_ff[DIV_ST][l];
         flip = ph[31] ^ ph[30];
         ph[31] = ph[31] ^ flip;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff[0][l] <= GAIN_INV_Q30;
            ry_ff[0][l] <= '0;
            rz_ff[0][l] <= 33'(signed'(ph));
            rflip_ff[0][l] <= flip;
         end
      end
   end

   for (genvar s = 1; s <= CORDIC_ITERS; s++) begin : g_rot
      localparam int K = s - 1;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         cor_type   x_in;
         cor_type   y_in;
         phase_type z_in;
         always_comb begin
            if (!rz_ff[s-1][l][32]) begin
               x_in = rx_ff[s-1][l] - (ry_ff[s-1][l] >>> K);
               y_in = ry_ff[s-1][l] + (rx_ff[s-1][l] >>> K);
               z_in = rz_ff[s-1][l] - atan_phase(K);
            end else begin
               x_in = rx_ff[s-1][l] + (ry_ff[s-1][l] >>> K);
               y_in = ry_ff[s-1][l] - (rx_ff[s-1][l] >>> K);
               z_in = rz_ff[s-1][l] + atan_phase(K);
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               rx_ff[s][l] <= x_in;
               ry_ff[s][l] <= y_in;
               rz_ff[s][l] <= z_in;
               rflip_ff[s][l] <= rflip_ff[s-1][l];
            end
         end
      end
   end

   // Sines of the half differences, cosines of the latitudes.
   q30_type sc_ff [0:LANES-1];

   for (genvar l = 0; l < LANES; l++) begin : g_sc
      cor_type v;
      always_comb begin
         v = (l < 2) ? ry_ff[CORDIC_ITERS][l] : rx_ff[CORDIC_ITERS][l];
         if (rflip_ff[CORDIC_ITERS][l]) begin
            v = -v;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sc_ff[l] <= clamp_q30(v);
         end
      end
   end

   q30_type m1_sl2_ff;
   q30_type m1_sn2_ff;
   q30_type m1_cc_ff;
   q30_type m2_sl2_ff;
   q30_type m2_t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_sl2_ff <= mulq(sc_ff[0], sc_ff[0]);
         m1_sn2_ff <= mulq(sc_ff[1], sc_ff[1]);
         m1_cc_ff <= mulq(sc_ff[2], sc_ff[3]);
         m2_sl2_ff <= m1_sl2_ff;
         m2_t_ff <= mulq(m1_cc_ff, m1_sn2_ff);
      end
   end

   // Square roots of a and 1 - a, one root bit per stage.
   logic [61:0] qnum_ff  [0:SQRT_STEPS][0:1];
   logic [34:0] qrem_ff  [0:SQRT_STEPS][0:1];
   logic [30:0] qroot_ff [0:SQRT_STEPS][0:1];

   logic signed [32:0] asum;
   logic [30:0]        aval;

   always_comb begin
      asum = 33'(m2_sl2_ff) + 33'(m2_t_ff);
      if (asum[32]) begin
         aval = '0;
      end else if (asum > 33'sd1073741824) begin
         aval = ONE_Q30;
      end else begin
         aval = 31'(asum);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qnum_ff[0][0] <= {1'b0, aval, 30'b0};
         qnum_ff[0][1] <= {1'b0, 31'(ONE_Q30 - aval), 30'b0};
         qrem_ff[0][0] <= '0;
         qrem_ff[0][1] <= '0;
         qroot_ff[0][0] <= '0;
         qroot_ff[0][1] <= '0;
      end
   end

   for (genvar s = 1; s <= SQRT_STEPS; s++) begin : g_sqrt
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [34:0] r4;
         logic [34:0] trial;
         logic [34:0] rem_in;
         logic [30:0] root_in;
         always_comb begin
            r4 = {qrem_ff[s-1][l][32:0], qnum_ff[s-1][l][61:60]};
            trial = {2'b00, qroot_ff[s-1][l], 2'b01};
            if (r4 >= trial) begin
               rem_in = r4 - trial;
               root_in = {qroot_ff[s-1][l][29:0], 1'b1};
            end else begin
               rem_in = r4;
               root_in = {qroot_ff[s-1][l][29:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               qnum_ff[s][l] <= qnum_ff[s-1][l] << 2;
               qrem_ff[s][l] <= rem_in;
               qroot_ff[s][l] <= root_in;
            end
         end
      end
   end

   // Vectoring CORDIC for atan2(sqrt(a), sqrt(1 - a)).
   cor_type   vx_ff [0:CORDIC_ITERS];
   cor_type   vy_ff [0:CORDIC_ITERS];
   phase_type vz_ff [0:CORDIC_ITERS];

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff[0] <= signed'(34'(qroot_ff[SQRT_STEPS][1]));
         vy_ff[0] <= signed'(34'(qroot_ff[SQRT_STEPS][0]));
         vz_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s <= CORDIC_ITERS; s++) begin : g_vec
      localparam int K = s - 1;
      cor_type   x_in;
      cor_type   y_in;
      phase_type z_in;
      always_comb begin
         if (!vy_ff[s-1][33]) begin
            x_in = vx_ff[s-1] + (vy_ff[s-1] >>> K);
            y_in = vy_ff[s-1] - (vx_ff[s-1] >>> K);
            z_in = vz_ff[s-1] + atan_phase(K);
         end else begin
            x_in = vx_ff[s-1] - (vy_ff[s-1] >>> K);
            y_in = vy_ff[s-1] + (vx_ff[s-1] >>> K);
            z_in = vz_ff[s-1] - atan_phase(K);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            vx_ff[s] <= x_in;
            vy_ff[s] <= y_in;
            vz_ff[s] <= z_in;
         end
      end
   end

   // Scale the central angle to distance; the 33-bit scale is split in two.
   logic [30:0] zc_ff;
   logic [46:0] pph_ff;
   logic [47:0] ppl_ff;
   logic [24:0] dist_ff;
   logic [30:0] zc_in;
   logic [64:0] dsum;
   logic [26:0] dq;

   always_comb begin
      if (vz_ff[CORDIC_ITERS][32]) begin
         zc_in = '0;
      end else if (vz_ff[CORDIC_ITERS] > 33'sd1073741824) begin
         zc_in = ONE_Q30;
      end else begin
         zc_in = 31'(vz_ff[CORDIC_ITERS]);
      end
      dsum = (65'(pph_ff) << 17) + 65'(ppl_ff) + (65'd1 << 37);
      dq = dsum[64:38];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zc_ff <= zc_in;
         pph_ff <= 47'(zc_ff) * 47'(DIST_SCALE[32:17]);
         ppl_ff <= 48'(zc_ff) * 48'(DIST_SCALE[16:0]);
         dist_ff <= (|dq[26:25]) ? 25'h1FF_FFFF : dq[24:0];
      end
   end

   assign rsp_distance = dist_ff;

endmodule
